// File: hdl/crc8rfc_pkg.sv
package crc8rfc_pkg;

    localparam int PAYLOAD_BYTES_DEFAULT = 8;

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [7:0] CRC_INIT      = 8'h00;

    localparam int ACK_FRAME_LEN   = 4;
    localparam int OVERHEAD_BYTES  = 4;
    localparam int POS_LENGTH      = 2;
    localparam int POS_PAYLOAD     = 3;

    localparam logic [7:0] LENGTH_OK_VALUE = 8'd1;

    localparam logic [1:0] ST_PAYLOAD    = 2'd0;
    localparam logic [1:0] ST_ACK_OK     = 2'd1;
    localparam logic [1:0] ST_ACK_BADLEN = 2'd2;
    localparam logic [1:0] ST_CRC_ERR    = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       last;
    } out_item_t;

    // frame verdict handed from the front to the queue
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } push_ctl_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } head_ctl_t;

    // reflected crc-8 (dallas/maxim), one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// File: hdl/crc8_response_frame_checker_core.sv
// Checks received response frames (device id, function code, length, payload,
// crc-8 dallas/maxim) one byte per transfer. The front end takes one byte every
// cycle, running the crc and buffering payload; at the frame's final byte it
// posts a verdict and a payload snapshot into a two-entry queue. The back end
// drains the queue through an output register at one result per cycle while
// out_ready is high: a good read frame gives PAYLOAD_BYTES results, any other
// verdict gives one. Input stalls only while both queue entries are occupied,
// so a read frame of PAYLOAD_BYTES+4 bytes sustains one byte per cycle when
// the output is not held off. ack_mode is written through the cfg channel,
// which is always ready, and must only change while the block is idle.
module crc8_response_frame_checker_core #(
    parameter int PAYLOAD_BYTES = crc8rfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  crc8rfc_pkg::in_item_t   in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output crc8rfc_pkg::out_item_t  out_data
);
    import crc8rfc_pkg::*;

    push_ctl_t                   push;
    head_ctl_t                   head;
    logic [PAYLOAD_BYTES*8-1:0]  snap_payload;
    logic [PAYLOAD_BYTES*8-1:0]  head_payload;
    logic                        q_full;
    logic                        pop;
    logic                        in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    crc8rfc_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_ack_mode (cfg_data),
        .accept       (in_accept),
        .item         (in_data),
        .push         (push),
        .payload      (snap_payload)
    );

    crc8rfc_queue #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_payload (snap_payload),
        .pop          (pop),
        .full         (q_full),
        .head         (head),
        .head_payload (head_payload)
    );

    crc8rfc_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_payload (head_payload),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

`ifndef ASSERT_OFF
    a_verdict_single : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_PAYLOAD |-> out_data.last && out_data.data_byte == 8'd0)
        else $error("verdict result not a single zero-data transfer");

    a_run_is_payload : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.status == ST_PAYLOAD)
        else $error("non-payload result inside a run");

    a_stall_has_work : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> head.valid)
        else $error("input stalled with empty queue");
`endif

endmodule

// File: hdl/crc8rfc_front.sv
module crc8rfc_front #(
    parameter int PAYLOAD_BYTES = crc8rfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_ack_mode,
    input  logic                         accept,
    input  crc8rfc_pkg::in_item_t        item,
    output crc8rfc_pkg::push_ctl_t       push,
    output logic [PAYLOAD_BYTES*8-1:0]   payload
);
    import crc8rfc_pkg::*;

    localparam int IDX_W      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int READ_LEN   = PAYLOAD_BYTES + OVERHEAD_BYTES;
    localparam int PAY_END    = POS_PAYLOAD + PAYLOAD_BYTES;

    logic       ack_mode_reg;
    logic [4:0] position_reg, position_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] length_reg, length_next;
    logic       open_reg, open_next;
    logic [7:0] store_reg [PAYLOAD_BYTES];

    logic       open_now;
    logic [4:0] pos_now;
    logic [7:0] crc_now;
    logic [4:0] final_pos;
    logic       is_final;
    logic       store_we;
    logic [4:0] store_off;
    logic [IDX_W-1:0] store_idx;

    always_comb
    begin
        open_now  = item.first_byte | open_reg;
        pos_now   = item.first_byte ? 5'd0 : position_reg;
        crc_now   = item.first_byte ? CRC_INIT : crc_reg;
        final_pos = ack_mode_reg ? 5'(ACK_FRAME_LEN - 1) : 5'(READ_LEN - 1);
        is_final  = pos_now >= final_pos;
        store_off = pos_now - 5'(POS_PAYLOAD);
        store_idx = store_off[IDX_W-1:0];

        position_next = position_reg;
        crc_next      = crc_reg;
        length_next   = length_reg;
        open_next     = open_reg;
        store_we      = 1'b0;
        push          = '0;

        if (accept && open_now)
        begin
            if (!is_final)
            begin
                crc_next      = crc8_step(crc_now, item.rx_byte);
                position_next = pos_now + 5'd1;
                open_next     = 1'b1;
                if (pos_now == 5'(POS_LENGTH))
                begin
                    length_next = item.rx_byte;
                end
                store_we = (pos_now >= 5'(POS_PAYLOAD)) && (pos_now < 5'(PAY_END));
            end
            else
            begin
                open_next     = 1'b0;
                position_next = pos_now;
                crc_next      = crc_now;
                push.valid    = 1'b1;
                if (item.rx_byte != crc_now)
                begin
                    push.status = ST_CRC_ERR;
                end
                else if (ack_mode_reg)
                begin
                    push.status = (length_reg == LENGTH_OK_VALUE) ? ST_ACK_OK : ST_ACK_BADLEN;
                end
                else
                begin
                    push.status = ST_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_mode_reg <= 1'b0;
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            length_reg   <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ack_mode_reg <= cfg_ack_mode;
            end
            position_reg <= position_next;
            crc_reg      <= crc_next;
            length_reg   <= length_next;
            open_reg     <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= item.rx_byte;
        end
    end

    // snapshot of the whole buffer, taken by the queue on a push
    generate
        for (genvar g = 0; g < PAYLOAD_BYTES; g++)
        begin : g_snap
            assign payload[g*8 +: 8] = store_reg[g];
        end
    endgenerate

endmodule

// File: hdl/crc8rfc_queue.sv
module crc8rfc_queue #(
    parameter int PAYLOAD_BYTES = crc8rfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crc8rfc_pkg::push_ctl_t       push,
    input  logic [PAYLOAD_BYTES*8-1:0]   push_payload,
    input  logic                         pop,
    output logic                         full,
    output crc8rfc_pkg::head_ctl_t       head,
    output logic [PAYLOAD_BYTES*8-1:0]   head_payload
);
    import crc8rfc_pkg::*;

    localparam int DEPTH = 2;

    logic [1:0] status_reg [DEPTH];
    logic [PAYLOAD_BYTES*8-1:0] payload_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    always_comb
    begin
        full         = count_reg == 2'(DEPTH);
        head.valid   = count_reg != 2'd0;
        head.status  = status_reg[rd_ptr_reg];
        head_payload = payload_reg[rd_ptr_reg];
        do_pop       = pop && head.valid;

        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push.valid) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            status_reg[wr_ptr_reg]  <= push.status;
            payload_reg[wr_ptr_reg] <= push_payload;
        end
    end

endmodule

// File: hdl/crc8rfc_back.sv
module crc8rfc_back #(
    parameter int PAYLOAD_BYTES = crc8rfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crc8rfc_pkg::head_ctl_t       head,
    input  logic [PAYLOAD_BYTES*8-1:0]   head_payload,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output crc8rfc_pkg::out_item_t       out_data
);
    import crc8rfc_pkg::*;

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic             valid_reg, valid_next;
    out_item_t        data_reg, data_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             load;
    logic             at_end;

    always_comb
    begin
        load       = head.valid && (!valid_reg || out_ready);
        at_end     = idx_reg == IDX_W'(PAYLOAD_BYTES - 1);
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            data_next.status = head.status;
            if (head.status == ST_PAYLOAD)
            begin
                data_next.data_byte = head_payload[idx_reg*8 +: 8];
                data_next.last      = at_end;
                pop                 = at_end;
                idx_next            = at_end ? '0 : idx_reg + IDX_W'(1);
            end
            else
            begin
                // verdict-only frames give a single result
                data_next.data_byte = '0;
                data_next.last      = 1'b1;
                pop                 = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: test/crc8_response_frame_checker_core_test.sv
module crc8_response_frame_checker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8rfc_pkg::*;

    localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RUN_LIMIT     = 200000;
    localparam int SIDE_TX       = 0;
    localparam int SIDE_RX       = 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    crc8_response_frame_checker_core #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0] crc_lut [256];

    // receiver-side view of the frame, advanced on every accepted byte
    logic       ack_cfg = 1'b0;
    int         rx_pos  = 0;
    logic [7:0] rx_crc  = CRC_INIT;
    logic [7:0] rx_length = '0;
    logic [7:0] rx_payload [PAYLOAD_BYTES];
    logic       rx_open = 1'b0;
    out_item_t  awaited_results [$];

    // stimulus side: the frame being built and its crc
    in_item_t   tx_bytes [$];
    int         gen_body_len = PAYLOAD_BYTES + POS_PAYLOAD;
    int         gen_pos = 0;
    logic [7:0] gen_crc = CRC_INIT;
    logic       gen_open = 1'b0;
    int         frame_bytes = 0;

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int mode_writes  = 0;
    int errors       = 0;
    int cycle_count  = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int calm_left [2] = '{0, 0};
    int tx_gap = 0;
    int rx_stall = 0;

    function automatic int pick_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void follow_rx_byte(input in_item_t it);
        int        flen;
        int        k;
        out_item_t r;
        if (it.first_byte)
        begin
            rx_pos  = 0;
            rx_crc  = CRC_INIT;
            rx_open = 1'b1;
        end
        if (!rx_open)
            return;
        // frame length follows the mode in force for this byte
        flen = ack_cfg ? ACK_FRAME_LEN : PAYLOAD_BYTES + OVERHEAD_BYTES;
        if (rx_pos + 1 < flen)
        begin
            rx_crc = crc_lut[rx_crc ^ it.rx_byte];
            if (rx_pos == POS_LENGTH)
                rx_length = it.rx_byte;
            if (rx_pos >= POS_PAYLOAD && rx_pos < POS_PAYLOAD + PAYLOAD_BYTES)
                rx_payload[rx_pos - POS_PAYLOAD] = it.rx_byte;
            rx_pos++;
            return;
        end
        rx_open = 1'b0;
        r = '0;
        r.last = 1'b1;
        if (it.rx_byte != rx_crc)
        begin
            r.status = ST_CRC_ERR;
            awaited_results.push_back(r);
        end
        else if (ack_cfg)
        begin
            r.status = (rx_length == LENGTH_OK_VALUE) ? ST_ACK_OK : ST_ACK_BADLEN;
            awaited_results.push_back(r);
        end
        else
        begin
            for (k = 0; k < PAYLOAD_BYTES; k++)
            begin
                r.status    = ST_PAYLOAD;
                r.data_byte = rx_payload[k];
                r.last      = (k == PAYLOAD_BYTES - 1);
                awaited_results.push_back(r);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        in_item_t it;
        it.rx_byte    = b;
        it.first_byte = first;
        tx_bytes.push_back(it);
        bytes_queued++;
        if (first)
        begin
            gen_open = 1'b1;
            gen_pos  = 0;
            gen_crc  = CRC_INIT;
        end
        if (!gen_open)
            return;
        frame_bytes++;
        if (gen_pos >= gen_body_len)
            gen_open = 1'b0;
        else
        begin
            gen_crc = crc_lut[gen_crc ^ b];
            gen_pos++;
        end
    endtask

    task automatic send_body(input int upto, input logic [7:0] len_byte);
        while (gen_open && gen_pos < upto)
            send_byte((gen_pos == POS_LENGTH) ? len_byte : 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic close_frame(input bit bad);
        send_byte(bad ? gen_crc ^ 8'($urandom_range(1, 255)) : gen_crc, 1'b0);
    endtask

    function automatic logic [7:0] pick_length();
        if ($urandom_range(0, 1))
            return ack_cfg ? LENGTH_OK_VALUE : 8'(PAYLOAD_BYTES);
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ack_cfg      = m;
        gen_body_len = m ? POS_PAYLOAD : PAYLOAD_BYTES + POS_PAYLOAD;
        mode_writes++;
    endtask

    task automatic random_phase(input int budget);
        int start;
        int pick;
        start = frame_bytes;
        // a frame left open by the previous phase finishes under the new mode
        if (gen_open)
        begin
            send_body(gen_body_len, pick_length());
            close_frame($urandom_range(0, 3) == 0);
        end
        while (frame_bytes - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                send_body(gen_body_len, pick_length());
                close_frame(pick >= 70);
            end
            else if (pick < 92)
            begin
                // cut short, the next first byte abandons it
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                send_body($urandom_range(1, gen_body_len - 1), pick_length());
            end
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 1))
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_body($urandom_range(1, gen_body_len - 1), pick_length());
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                follow_rx_byte(in_data);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    in_data  <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= pick_gap(SIDE_TX);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        int        g;
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                status_seen[out_data.status]++;
                if (awaited_results.size() == 0)
                begin
                    $error("result with nothing pending: status %0d data %0h last %0b",
                           out_data.status, out_data.data_byte, out_data.last);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %02h, got %02h",
                               want.data_byte, out_data.data_byte);
                        errors++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, out_data.last);
                        errors++;
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall  <= rx_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                g = pick_gap(SIDE_RX);
                out_ready <= (g == 0);
                rx_stall  <= (g == 0) ? 0 : g - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timed out with %0d results outstanding", awaited_results.size());
            $display("crc8_response_frame_checker_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         i;
        int         k;
        int         ph;
        logic [7:0] x;
        for (i = 0; i < 256; i++)
        begin
            x = 8'(i);
            for (k = 0; k < 8; k++)
                x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
            crc_lut[i] = x;
        end
        foreach (rx_payload[k])
            rx_payload[k] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // read mode: stray byte before any frame, one clean frame, byte past its end
        wait_idle();
        write_mode(1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'(PAYLOAD_BYTES), 1'b0);
        for (k = 0; k < PAYLOAD_BYTES; k++)
            send_byte((k == 0) ? 8'h00 : ((k == 1) ? 8'hFF : 8'($urandom_range(0, 255))), 1'b0);
        close_frame(1'b0);
        send_byte(8'h00, 1'b0);

        // acknowledge mode: length ok, bad length, crc error, restart mid-frame
        wait_idle();
        write_mode(1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_body(gen_body_len, LENGTH_OK_VALUE);
        close_frame(1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_body(gen_body_len, 8'hFF);
        close_frame(1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_body(gen_body_len, LENGTH_OK_VALUE);
        close_frame(1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_body(gen_body_len, 8'h00);
        close_frame(1'b0);
        // left open, finished after the switch back to read mode
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);

        for (ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            write_mode(ph % 2 == 1);
            random_phase(32);
        end

        wait_idle();
        $display("%0d bytes accepted across %0d mode writes", bytes_taken, mode_writes);
        $display("results: %0d payload, %0d ack ok, %0d ack bad length, %0d crc error",
                 status_seen[ST_PAYLOAD], status_seen[ST_ACK_OK],
                 status_seen[ST_ACK_BADLEN], status_seen[ST_CRC_ERR]);
        if (errors == 0)
            $display("crc8_response_frame_checker_core_test: PASS");
        else
            $display("crc8_response_frame_checker_core_test: FAIL");
        $finish;
    end

endmodule
